// ===== rtl/core/imubr_pkg.sv =====
`timescale 1ns / 1ps

package imubr_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int COUNT_WIDTH  = 12;
	localparam int NUM_AXES     = 6;
	// a full window of worst-case samples fits without overflow
	localparam int SUM_WIDTH    = SAMPLE_WIDTH + COUNT_WIDTH;
	localparam int DATA_WIDTH   = SAMPLE_WIDTH * NUM_AXES;
	localparam int AXIS_W       = $clog2(NUM_AXES);
	localparam int BIT_W        = $clog2(SUM_WIDTH);

	localparam logic [COUNT_WIDTH-1:0] SAMPLE_COUNT_RESET = COUNT_WIDTH'(300);

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_RECAL  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_LOAD,
		ST_DIV_STEP,
		ST_DIV_STORE
	} state_t;

	typedef struct packed {
		logic              accum;
		logic              correct;
		logic              clear;
		logic              div_load;
		logic              div_step;
		logic              bias_wr;
		logic [AXIS_W-1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic will_complete;
	} status_t;

endpackage

// ===== rtl/core/imu_six_axis_bias_removal.sv =====
`timescale 1ns / 1ps

// six-axis imu bias removal. while estimating, every sensor sample is summed per axis and
// passed through raw (tuser = 0), one transaction per clock cycle while the output is not
// stalled. the sample that brings the count to sample_count or past it still comes out raw
// and then starts the bias division: one shared restoring divider produces each axis bias
// (sum / count, truncated toward zero) one quotient bit per cycle, and the input stalls while
// the divider walks all six axes. after that each sample comes out with its bias subtracted,
// saturated to 16 bits, with tuser = 1. a recalibrate transaction (tuser = 1 on the input)
// clears the sums, the sample counter and the ready flag and gives no output. a finished
// result waits in an output register, and the next input is taken in the same cycle that
// result is taken. sample_count may only be changed while the block is idle.
module imu_six_axis_bias_removal (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: sample count register
	input  logic                                cfg_we,
	input  logic [imubr_pkg::COUNT_WIDTH-1:0]   cfg_wdata,
	// input samples
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each, lowest first)
	input  logic [imubr_pkg::DATA_WIDTH-1:0]    s_axis_tdata,
	// opcode: 0 sample, 1 recalibrate
	input  logic                                s_axis_tuser,
	// output samples
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// accel_x_out, accel_y_out, accel_z_out, gyro_x_out, gyro_y_out, gyro_z_out
	output logic [imubr_pkg::DATA_WIDTH-1:0]    m_axis_tdata,
	// corrected: 0 raw, 1 bias subtracted
	output logic                                m_axis_tuser
);

	logic [imubr_pkg::COUNT_WIDTH-1:0] sample_count_q;
	imubr_pkg::cmd_t                   cmd;
	imubr_pkg::status_t                status;

	// sample count register, to be written only while idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= imubr_pkg::SAMPLE_COUNT_RESET;
		end else if (cfg_we) begin
			sample_count_q <= cfg_wdata;
		end
	end

	// controller: accept decisions and divide sequencing
	imubr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_opcode (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: sums, divider, biases, output register
	imubr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_count  (sample_count_q),
		.in_data       (s_axis_tdata),
		.out_data      (m_axis_tdata),
		.out_corrected (m_axis_tuser),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.cmd           (cmd),
		.status        (status)
	);

endmodule

// ===== rtl/core/imubr_ctrl.sv =====
`timescale 1ns / 1ps

module imubr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_opcode,
	output logic               in_ready,
	input  imubr_pkg::status_t status,
	output imubr_pkg::cmd_t    cmd
);

	imubr_pkg::state_t                state_q, state_d;
	logic [imubr_pkg::AXIS_W-1:0]     axis_q, axis_d;
	logic [imubr_pkg::BIT_W-1:0]      bit_q, bit_d;
	logic                             bias_ready_q, bias_ready_d;
	logic                             accept;

	localparam logic [imubr_pkg::AXIS_W-1:0] LAST_AXIS =
		imubr_pkg::AXIS_W'(imubr_pkg::NUM_AXES - 1);
	localparam logic [imubr_pkg::BIT_W-1:0] LAST_BIT =
		imubr_pkg::BIT_W'(imubr_pkg::SUM_WIDTH - 1);

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= imubr_pkg::ST_IDLE;
			axis_q       <= '0;
			bit_q        <= '0;
			bias_ready_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			axis_q       <= axis_d;
			bit_q        <= bit_d;
			bias_ready_q <= bias_ready_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		axis_d       = axis_q;
		bit_d        = bit_q;
		bias_ready_d = bias_ready_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.axis     = axis_q;
		case (state_q)
			imubr_pkg::ST_IDLE: begin
				in_ready = status.out_free;
				if (accept) begin
					if (in_opcode == imubr_pkg::OP_RECAL) begin
						cmd.clear    = 1'b1;
						bias_ready_d = 1'b0;
					end else if (bias_ready_q) begin
						cmd.correct = 1'b1;
					end else begin
						cmd.accum = 1'b1;
						if (status.will_complete) begin
							state_d = imubr_pkg::ST_DIV_LOAD;
							axis_d  = '0;
						end
					end
				end
			end
			imubr_pkg::ST_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				bit_d        = LAST_BIT;
				state_d      = imubr_pkg::ST_DIV_STEP;
			end
			imubr_pkg::ST_DIV_STEP: begin
				cmd.div_step = 1'b1;
				if (bit_q == '0) begin
					state_d = imubr_pkg::ST_DIV_STORE;
				end else begin
					bit_d = bit_q - 1'b1;
				end
			end
			imubr_pkg::ST_DIV_STORE: begin
				cmd.bias_wr = 1'b1;
				if (axis_q == LAST_AXIS) begin
					bias_ready_d = 1'b1;
					state_d      = imubr_pkg::ST_IDLE;
				end else begin
					axis_d  = axis_q + 1'b1;
					state_d = imubr_pkg::ST_DIV_LOAD;
				end
			end
			default: begin
				state_d = imubr_pkg::ST_IDLE;
			end
		endcase
	end

	a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != imubr_pkg::ST_IDLE) |-> !in_ready)
		else $error("input accepted during bias division");

	a_ready_after_last_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == imubr_pkg::ST_DIV_STORE && axis_q == LAST_AXIS)
		|=> (bias_ready_q && state_q == imubr_pkg::ST_IDLE))
		else $error("bias not marked ready after last axis");

	a_recal_clears_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_opcode == imubr_pkg::OP_RECAL) |=> !bias_ready_q)
		else $error("recalibrate did not clear bias ready");

	a_complete_starts_divide: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accum && status.will_complete) |=> (state_q == imubr_pkg::ST_DIV_LOAD
		&& axis_q == '0))
		else $error("completed window did not start division");

endmodule

// ===== rtl/core/imubr_dp.sv =====
`timescale 1ns / 1ps

module imubr_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [imubr_pkg::COUNT_WIDTH-1:0]   sample_count,
	input  logic [imubr_pkg::DATA_WIDTH-1:0]    in_data,
	output logic [imubr_pkg::DATA_WIDTH-1:0]    out_data,
	output logic                                out_corrected,
	output logic                                out_valid,
	input  logic                                out_ready,
	input  imubr_pkg::cmd_t                     cmd,
	output imubr_pkg::status_t                  status
);

	localparam int SW = imubr_pkg::SAMPLE_WIDTH;
	localparam int CW = imubr_pkg::COUNT_WIDTH;
	localparam int UW = imubr_pkg::SUM_WIDTH;
	localparam int NA = imubr_pkg::NUM_AXES;

	logic signed [UW-1:0] sums_q [NA];
	logic signed [SW-1:0] bias_q [NA];
	logic [CW-1:0]        seen_q;
	logic [CW-1:0]        seen_inc;

	logic [CW-1:0]        rem_q;
	logic [UW-1:0]        dq_q;
	logic                 neg_q;
	logic [CW:0]          trial;
	logic                 qbit;
	logic signed [UW-1:0] sel_sum;
	logic [UW-1:0]        quot;

	logic                 out_valid_q;
	logic                 out_corr_q;
	logic [SW-1:0]        out_q [NA];

	logic signed [SW-1:0] smp [NA];
	logic [SW-1:0]        corr [NA];

	assign seen_inc = seen_q + 1'b1;
	assign status.will_complete = (seen_inc >= sample_count) && (seen_inc != '0);
	assign status.out_free = !out_valid_q || out_ready;

	// per-axis sample split and saturating subtract
	always_comb begin
		logic signed [SW:0] diff;
		for (int i = 0; i < NA; i++) begin
			smp[i] = in_data[i*SW +: SW];
			diff   = {smp[i][SW-1], smp[i]} - {bias_q[i][SW-1], bias_q[i]};
			if (diff[SW] != diff[SW-1]) begin
				corr[i] = diff[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
			end else begin
				corr[i] = diff[SW-1:0];
			end
		end
	end

	// restoring divide, one quotient bit a step
	assign sel_sum = sums_q[cmd.axis];
	assign trial   = {rem_q, dq_q[UW-1]};
	assign qbit    = (trial >= {1'b0, seen_q});
	assign quot    = neg_q ? (~dq_q + 1'b1) : dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int i = 0; i < NA; i++) begin
				sums_q[i] <= '0;
				bias_q[i] <= '0;
			end
		end else begin
			if (cmd.clear) begin
				seen_q <= '0;
				for (int i = 0; i < NA; i++) begin
					sums_q[i] <= '0;
				end
			end else if (cmd.accum) begin
				seen_q <= seen_inc;
				for (int i = 0; i < NA; i++) begin
					sums_q[i] <= sums_q[i] + UW'(smp[i]);
				end
			end
			if (cmd.bias_wr) begin
				bias_q[cmd.axis] <= quot[SW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			neg_q <= sel_sum[UW-1];
			dq_q  <= sel_sum[UW-1] ? UW'(-sel_sum) : UW'(sel_sum);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= qbit ? CW'(trial - {1'b0, seen_q}) : trial[CW-1:0];
			dq_q  <= {dq_q[UW-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.accum || cmd.correct) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accum || cmd.correct) begin
			out_corr_q <= cmd.correct;
			for (int i = 0; i < NA; i++) begin
				out_q[i] <= cmd.correct ? corr[i] : smp[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			out_data[i*SW +: SW] = out_q[i];
		end
	end

	assign out_valid     = out_valid_q;
	assign out_corrected = out_corr_q;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	// the divider walks six axes, one quotient bit per cycle, after a window closes
	localparam int DIV_CYCLES   = imubr_pkg::NUM_AXES * 30;
	localparam int HOLD_CYCLES  = DIV_CYCLES + 70;
	localparam int RANDOM_ITEMS = 1150;
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct packed {
		logic                             corrected;
		logic [imubr_pkg::DATA_WIDTH-1:0] axes;
	} imu_result_t;

	// optional hand-typed result for one transaction, in send order
	typedef struct packed {
		logic        typed;
		imu_result_t res;
	} hand_claim_t;

	typedef enum logic [1:0] {
		ROW_COUNT,
		ROW_SAMPLE,
		ROW_RECAL
	} row_kind_t;

	typedef struct packed {
		row_kind_t                         kind;
		logic [imubr_pkg::COUNT_WIDTH-1:0] count;
		logic [imubr_pkg::DATA_WIDTH-1:0]  data;
		logic                              typed;
		imu_result_t                       res;
	} plan_row_t;

	logic                              clk;
	logic                              arst_n        = 1'b0;
	logic                              cfg_we        = 1'b0;
	logic [imubr_pkg::COUNT_WIDTH-1:0] cfg_wdata     = '0;
	logic                              s_axis_tvalid = 1'b0;
	logic                              s_axis_tready;
	logic [imubr_pkg::DATA_WIDTH-1:0]  s_axis_tdata  = '0;
	logic                              s_axis_tuser  = imubr_pkg::OP_SAMPLE;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 1'b0;
	logic [imubr_pkg::DATA_WIDTH-1:0]  m_axis_tdata;
	logic                              m_axis_tuser;

	imu_six_axis_bias_removal uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// shadow of the calibration state
	logic [imubr_pkg::COUNT_WIDTH-1:0]         window_len = imubr_pkg::SAMPLE_COUNT_RESET;
	logic [imubr_pkg::COUNT_WIDTH-1:0]         seen_n     = '0;
	logic                                      bias_ok    = 1'b0;
	logic signed [imubr_pkg::SUM_WIDTH-1:0]    axis_sum  [imubr_pkg::NUM_AXES];
	logic signed [imubr_pkg::SAMPLE_WIDTH-1:0] axis_bias [imubr_pkg::NUM_AXES];

	imu_result_t due_samples [$];
	hand_claim_t hand_results [$];
	plan_row_t   plan [$];

	string axis_names [imubr_pkg::NUM_AXES] = '{"accel_x", "accel_y", "accel_z",
		"gyro_x", "gyro_y", "gyro_z"};

	int cycles         = 0;
	int fed_items      = 0;
	int recals_taken   = 0;
	int windows_done   = 0;
	int count_writes   = 0;
	int results_checked = 0;
	int corrected_seen = 0;
	int mismatches     = 0;

	// a long run of transactions with no idling on either side
	wire calm = (fed_items >= 450) && (fed_items < 650);

	initial begin
		for (int i = 0; i < imubr_pkg::NUM_AXES; i++) begin
			axis_sum[i]  = '0;
			axis_bias[i] = '0;
		end
	end

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles,
				due_samples.size());
			$display("FAIL imu_six_axis_bias_removal");
			$finish;
		end
	end

	// one sample or recalibrate through the calibration state; returns 1 when a result is due
	function automatic bit debias_step(input logic op,
			input logic [imubr_pkg::DATA_WIDTH-1:0] d, output imu_result_t r);
		logic signed [imubr_pkg::SAMPLE_WIDTH-1:0] s;
		logic signed [imubr_pkg::SAMPLE_WIDTH:0]   diff;
		logic signed [imubr_pkg::SUM_WIDTH-1:0]    q;
		r = '0;
		if (op == imubr_pkg::OP_RECAL) begin
			seen_n  = '0;
			bias_ok = 1'b0;
			for (int i = 0; i < imubr_pkg::NUM_AXES; i++)
				axis_sum[i] = '0;
			return 1'b0;
		end
		if (!bias_ok) begin
			for (int i = 0; i < imubr_pkg::NUM_AXES; i++) begin
				s = d[i*imubr_pkg::SAMPLE_WIDTH +: imubr_pkg::SAMPLE_WIDTH];
				axis_sum[i] = axis_sum[i] + imubr_pkg::SUM_WIDTH'(s);
			end
			seen_n = seen_n + 1'b1;
			// a count of zero closes on the first sample, like a count of one
			if (seen_n >= window_len && seen_n != 0) begin
				for (int i = 0; i < imubr_pkg::NUM_AXES; i++) begin
					q = axis_sum[i] / imubr_pkg::SUM_WIDTH'($signed({1'b0, seen_n}));
					axis_bias[i] = q[imubr_pkg::SAMPLE_WIDTH-1:0];
				end
				bias_ok = 1'b1;
				windows_done++;
			end
			r.corrected = 1'b0;
			r.axes      = d;
		end else begin
			for (int i = 0; i < imubr_pkg::NUM_AXES; i++) begin
				s = d[i*imubr_pkg::SAMPLE_WIDTH +: imubr_pkg::SAMPLE_WIDTH];
				diff = (imubr_pkg::SAMPLE_WIDTH+1)'(s)
					- (imubr_pkg::SAMPLE_WIDTH+1)'(axis_bias[i]);
				if (diff > 17'sd32767)
					r.axes[i*imubr_pkg::SAMPLE_WIDTH +: imubr_pkg::SAMPLE_WIDTH] = 16'h7fff;
				else if (diff < -17'sd32768)
					r.axes[i*imubr_pkg::SAMPLE_WIDTH +: imubr_pkg::SAMPLE_WIDTH] = 16'h8000;
				else
					r.axes[i*imubr_pkg::SAMPLE_WIDTH +: imubr_pkg::SAMPLE_WIDTH] =
						diff[imubr_pkg::SAMPLE_WIDTH-1:0];
			end
			r.corrected = 1'b1;
		end
		return 1'b1;
	endfunction

	// input side: every accepted transaction moves the shadow state
	always @(posedge clk) begin
		imu_result_t r;
		hand_claim_t c;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			c = '0;
			if (hand_results.size() != 0)
				c = hand_results.pop_front();
			if (s_axis_tuser == imubr_pkg::OP_RECAL)
				recals_taken++;
			if (debias_step(s_axis_tuser, s_axis_tdata, r))
				due_samples.push_back(c.typed ? c.res : r);
		end
	end

	task automatic report_mismatch(input string field, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s at result %0d: expected %0d, got %0d", field,
				results_checked, want, got);
	endtask

	// output side: compare each accepted result field by field with the oldest one due
	always @(posedge clk) begin
		imu_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result with nothing due: tuser %0b tdata %h", m_axis_tuser,
						m_axis_tdata);
			end else begin
				want = due_samples.pop_front();
				results_checked++;
				if (m_axis_tuser === 1'b1)
					corrected_seen++;
				if (m_axis_tuser !== want.corrected)
					report_mismatch("corrected", int'(want.corrected), int'(m_axis_tuser));
				for (int i = 0; i < imubr_pkg::NUM_AXES; i++) begin
					if (m_axis_tdata[i*imubr_pkg::SAMPLE_WIDTH +: imubr_pkg::SAMPLE_WIDTH] !==
							want.axes[i*imubr_pkg::SAMPLE_WIDTH +: imubr_pkg::SAMPLE_WIDTH])
						report_mismatch(axis_names[i],
							int'($signed(want.axes[i*imubr_pkg::SAMPLE_WIDTH +:
								imubr_pkg::SAMPLE_WIDTH])),
							int'($signed(m_axis_tdata[i*imubr_pkg::SAMPLE_WIDTH +:
								imubr_pkg::SAMPLE_WIDTH])));
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 15);
	end

	task automatic push_item(input logic op, input logic [imubr_pkg::DATA_WIDTH-1:0] d,
			input logic typed, input imu_result_t typed_res);
		hand_claim_t c;
		c.typed = typed;
		c.res   = typed_res;
		hand_results.push_back(c);
		while (!calm && $urandom_range(0, 99) < 15) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		fed_items++;
	endtask

	// stop sending, let every result arrive, then give a closing division time to finish
	task automatic settle_block();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (due_samples.size() != 0)
			@(posedge clk);
		repeat (HOLD_CYCLES) @(posedge clk);
	endtask

	task automatic set_count(input logic [imubr_pkg::COUNT_WIDTH-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we     <= 1'b0;
		window_len = v;
		count_writes++;
	endtask

	function automatic logic [imubr_pkg::DATA_WIDTH-1:0] every_axis(
			input logic [imubr_pkg::SAMPLE_WIDTH-1:0] v);
		return {imubr_pkg::NUM_AXES{v}};
	endfunction

	function automatic logic [imubr_pkg::DATA_WIDTH-1:0] noise_data();
		return {$urandom, $urandom, $urandom};
	endfunction

	function automatic plan_row_t sample_row(input logic [imubr_pkg::DATA_WIDTH-1:0] d,
			input logic typed, input logic corr, input logic [imubr_pkg::DATA_WIDTH-1:0] out);
		plan_row_t row;
		row.kind          = ROW_SAMPLE;
		row.count         = '0;
		row.data          = d;
		row.typed         = typed;
		row.res.corrected = corr;
		row.res.axes      = out;
		return row;
	endfunction

	function automatic plan_row_t count_row(input logic [imubr_pkg::COUNT_WIDTH-1:0] v);
		plan_row_t row;
		row       = '0;
		row.kind  = ROW_COUNT;
		row.count = v;
		return row;
	endfunction

	function automatic plan_row_t recal_row();
		plan_row_t row;
		row      = '0;
		row.kind = ROW_RECAL;
		row.data = noise_data();
		return row;
	endfunction

	// shape 0: full random, shape 1: near a per-phase offset, shape 2: mostly extremes
	function automatic logic [imubr_pkg::DATA_WIDTH-1:0] make_sample(input int shape,
			input logic [imubr_pkg::DATA_WIDTH-1:0] base);
		logic [imubr_pkg::DATA_WIDTH-1:0]          d;
		logic signed [imubr_pkg::SAMPLE_WIDTH-1:0] lvl;
		int v;
		int noise;
		for (int i = 0; i < imubr_pkg::NUM_AXES; i++) begin
			case (shape)
				0: d[i*imubr_pkg::SAMPLE_WIDTH +: imubr_pkg::SAMPLE_WIDTH] =
					imubr_pkg::SAMPLE_WIDTH'($urandom);
				1: begin
					lvl   = base[i*imubr_pkg::SAMPLE_WIDTH +: imubr_pkg::SAMPLE_WIDTH];
					v     = int'(lvl);
					noise = $urandom_range(0, 512);
					v     = v + noise - 256;
					if (v > 32767)
						v = 32767;
					if (v < -32768)
						v = -32768;
					d[i*imubr_pkg::SAMPLE_WIDTH +: imubr_pkg::SAMPLE_WIDTH] =
						v[imubr_pkg::SAMPLE_WIDTH-1:0];
				end
				default: begin
					case ($urandom_range(0, 4))
						0: d[i*imubr_pkg::SAMPLE_WIDTH +: imubr_pkg::SAMPLE_WIDTH] = 16'h8000;
						1: d[i*imubr_pkg::SAMPLE_WIDTH +: imubr_pkg::SAMPLE_WIDTH] = 16'h7fff;
						2: d[i*imubr_pkg::SAMPLE_WIDTH +: imubr_pkg::SAMPLE_WIDTH] = 16'h0000;
						3: d[i*imubr_pkg::SAMPLE_WIDTH +: imubr_pkg::SAMPLE_WIDTH] = 16'hffff;
						default: d[i*imubr_pkg::SAMPLE_WIDTH +: imubr_pkg::SAMPLE_WIDTH] =
							imubr_pkg::SAMPLE_WIDTH'($urandom);
					endcase
				end
			endcase
		end
		return d;
	endfunction

	initial begin
		int                                pick;
		int                                span;
		int                                shape;
		int                                rand_fed;
		logic [imubr_pkg::COUNT_WIDTH-1:0] next_len;
		logic [imubr_pkg::DATA_WIDTH-1:0]  base;

		// raw pass-through at reset, then a full-scale window that drives positive saturation
		plan.push_back(sample_row(every_axis(16'h7fff), 1'b1, 1'b0, every_axis(16'h7fff)));
		plan.push_back(recal_row());
		plan.push_back(count_row(12'd2));
		plan.push_back(sample_row(every_axis(16'h8000), 1'b1, 1'b0, every_axis(16'h8000)));
		plan.push_back(sample_row(every_axis(16'h8000), 1'b1, 1'b0, every_axis(16'h8000)));
		plan.push_back(sample_row(every_axis(16'h7fff), 1'b1, 1'b1, every_axis(16'h7fff)));
		plan.push_back(sample_row(every_axis(16'h8000), 1'b1, 1'b1, every_axis(16'h0000)));
		plan.push_back(sample_row({16'h00ff, 16'h7ffe, 16'h8001, 16'h0001, 16'hfedc, 16'h1234},
			1'b0, 1'b0, '0));
		plan.push_back(recal_row());
		// a count of zero closes the window on its first sample
		plan.push_back(count_row(12'd0));
		plan.push_back(sample_row(every_axis(16'h7fff), 1'b1, 1'b0, every_axis(16'h7fff)));
		plan.push_back(sample_row(every_axis(16'h8000), 1'b1, 1'b1, every_axis(16'h8000)));
		plan.push_back(sample_row(every_axis(16'h0000), 1'b1, 1'b1, every_axis(16'h8001)));
		plan.push_back(recal_row());
		// largest count, then lowered mid-window: divides by the samples actually summed
		plan.push_back(count_row(12'd4095));
		plan.push_back(sample_row({16'h4000, 16'hc000, 16'h0123, 16'hfff0, 16'h7fff, 16'h8000},
			1'b0, 1'b0, '0));
		plan.push_back(sample_row({16'h3fff, 16'hc001, 16'h0456, 16'hffe0, 16'h7ff0, 16'h8010},
			1'b0, 1'b0, '0));
		plan.push_back(count_row(12'd1));
		plan.push_back(sample_row({16'h0001, 16'hffff, 16'h0789, 16'hffd0, 16'h7fe0, 16'h8020},
			1'b0, 1'b0, '0));
		plan.push_back(sample_row({16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h8000, 16'h7fff},
			1'b0, 1'b0, '0));
		plan.push_back(recal_row());
		// negative sum -3 over 2 truncates toward zero to -1
		plan.push_back(count_row(12'd2));
		plan.push_back(sample_row(every_axis(16'hfffd), 1'b1, 1'b0, every_axis(16'hfffd)));
		plan.push_back(sample_row(every_axis(16'h0000), 1'b1, 1'b0, every_axis(16'h0000)));
		plan.push_back(sample_row(every_axis(16'h0000), 1'b1, 1'b1, every_axis(16'h0001)));
		plan.push_back(sample_row(every_axis(16'h8000), 1'b1, 1'b1, every_axis(16'h8001)));
		// after a recalibrate the old biases are kept but unused
		plan.push_back(recal_row());
		plan.push_back(sample_row(every_axis(16'h0001), 1'b1, 1'b0, every_axis(16'h0001)));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			case (plan[k].kind)
				ROW_COUNT: begin
					settle_block();
					set_count(plan[k].count);
				end
				ROW_RECAL: push_item(imubr_pkg::OP_RECAL, plan[k].data, 1'b0, '0);
				default:   push_item(imubr_pkg::OP_SAMPLE, plan[k].data, plan[k].typed,
					plan[k].res);
			endcase
		end

		// random phases: a new count while idle, then a burst of samples with a few restarts
		rand_fed = 0;
		while (rand_fed < RANDOM_ITEMS) begin
			settle_block();
			pick = $urandom_range(0, 99);
			if (pick < 5)
				next_len = '0;
			else if (pick < 12)
				next_len = 12'd4095;
			else if (pick < 20)
				next_len = 12'd1;
			else
				next_len = imubr_pkg::COUNT_WIDTH'($urandom_range(2, 24));
			set_count(next_len);
			shape = $urandom_range(0, 2);
			base  = noise_data();
			if ($urandom_range(0, 3) == 0)
				base = every_axis($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
			span = (next_len == 12'd4095) ? $urandom_range(3, 20) : $urandom_range(10, 60);
			repeat (span) begin
				if ($urandom_range(0, 99) < 4)
					push_item(imubr_pkg::OP_RECAL, noise_data(), 1'b0, '0);
				else
					push_item(imubr_pkg::OP_SAMPLE, make_sample(shape, base), 1'b0, '0);
				rand_fed++;
			end
		end

		settle_block();

		$display("%0d transactions sent (%0d recalibrations), %0d results checked, %0d corrected",
			fed_items, recals_taken, results_checked, corrected_seen);
		$display("%0d estimation windows closed across %0d sample count writes, %0d mismatches",
			windows_done, count_writes, mismatches);
		if (mismatches == 0)
			$display("PASS imu_six_axis_bias_removal");
		else
			$display("FAIL imu_six_axis_bias_removal");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/imubr_pkg.sv
rtl/core/imubr_ctrl.sv
rtl/core/imubr_dp.sv
rtl/core/imu_six_axis_bias_removal.sv
tb/tb_top.sv
